// File: src/svt_pkg.sv
package svt_pkg;

  // Table geometry
  localparam int Capacity   = 16;
  localparam int MaxResults = 16;
  localparam int CntW       = $clog2(Capacity + 1);
  localparam int AddrW      = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int ValueW     = 32;
  localparam int EntryCntW  = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LIST   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ENTRY     = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_PLACE,
    S_EMIT
  } state_e;

  // Store access from the sequencer
  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  wr_addr;
    logic [ValueW-1:0] wr_data;
    logic              re;
    logic [AddrW-1:0]  rd_addr;
  } store_req_t;

endpackage

// File: src/sorted_value_table_top.sv
// Sorted value table: holds up to 16 signed 32-bit values in ascending order
// (duplicates kept) in a RAM with one write port and a registered read port.
// One item is worked at a time and in_stall_o stays high until its last
// result has been loaded into the output register. Each entry visited takes a
// RAM read, then a compare and shift write: insert walks down from the top
// over the entries not less than the value; delete walks up to the match and
// then shifts the rest; list emits one entry per read, waiting while the
// output is stalled. Full and empty cases go straight to their result; an
// unused command gives no result.
module sorted_value_table_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic signed [31:0]           operand_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic signed [31:0]           entry_value_o,
  output logic [4:0]                   entry_count_o,
  output logic                         last_o
);
  import svt_pkg::*;

  state_e                   state_q, state_d;
  cmd_e                     cmd_q, cmd_d;
  logic signed [ValueW-1:0] val_q, val_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [CntW-1:0]          idx_q, idx_d;
  logic                     found_q, found_d;
  status_e                  st_q, st_d;

  logic                     out_valid_q, out_valid_d;
  status_e                  out_st_q, out_st_d;
  logic [ValueW-1:0]        out_val_q, out_val_d;
  logic [CntW-1:0]          out_cnt_q, out_cnt_d;
  logic                     out_last_q, out_last_d;

  store_req_t               req;
  logic [ValueW-1:0]        rd_data;
  logic signed [ValueW-1:0] rd_s;
  logic                     in_acc;
  logic                     out_free;
  logic [CntW-1:0]          idx_m1;
  logic [CntW-1:0]          cnt_m1;
  logic [CntW-1:0]          list_n;
  logic                     match;
  logic                     greater;
  logic                     not_less;

  svt_store u_store (
    .clk_i     (clk_i),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign rd_s     = $signed(rd_data);
  assign idx_m1   = idx_q - CntW'(1);
  assign cnt_m1   = cnt_q - CntW'(1);
  assign list_n   = (cnt_q > CntW'(MaxResults)) ? CntW'(MaxResults) : cnt_q;
  assign match    = (rd_s == val_q);
  assign greater  = (rd_s > val_q);
  assign not_less = (rd_s >= val_q);

  // Sequencer: next state, store access and output loading
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    val_d      = val_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    found_d    = found_q;
    st_d       = st_q;

    out_valid_d = out_valid_q && out_stall_i;
    out_st_d    = out_st_q;
    out_val_d   = out_val_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;

    req.we      = 1'b0;
    req.wr_addr = idx_q[AddrW-1:0];
    req.wr_data = rd_data;
    req.re      = 1'b0;
    req.rd_addr = (cmd_q == CMD_INSERT) ? idx_m1[AddrW-1:0] : idx_q[AddrW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d   = cmd_e'(command_i);
          val_d   = operand_value_i;
          found_d = 1'b0;
          idx_d   = '0;
          case (cmd_e'(command_i))
            CMD_INSERT: begin
              if (cnt_q >= CntW'(Capacity)) begin
                st_d    = ST_FULL;
                state_d = S_EMIT;
              end else if (cnt_q == '0) begin
                state_d = S_PLACE;
              end else begin
                idx_d   = cnt_q;
                state_d = S_READ;
              end
            end
            CMD_DELETE: begin
              if (cnt_q == '0) begin
                st_d    = ST_NOT_FOUND;
                state_d = S_EMIT;
              end else begin
                state_d = S_READ;
              end
            end
            CMD_LIST: begin
              if (cnt_q == '0) begin
                st_d    = ST_EMPTY;
                state_d = S_EMIT;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_READ: begin
        req.re  = 1'b1;
        state_d = S_EVAL;
      end

      S_EVAL: begin
        case (cmd_q)
          // Walk down, moving entries not less than the value up one slot
          CMD_INSERT: begin
            if (not_less) begin
              req.we      = 1'b1;
              req.wr_addr = idx_q[AddrW-1:0];
              req.wr_data = rd_data;
              idx_d       = idx_m1;
              state_d     = (idx_q == CntW'(1)) ? S_PLACE : S_READ;
            end else begin
              state_d = S_PLACE;
            end
          end
          // Walk up to the match, then pull later entries down one slot
          CMD_DELETE: begin
            if (found_q) begin
              req.we      = 1'b1;
              req.wr_addr = idx_m1[AddrW-1:0];
              req.wr_data = rd_data;
            end
            if (!found_q && greater) begin
              st_d    = ST_NOT_FOUND;
              state_d = S_EMIT;
            end else begin
              found_d = found_q || match;
              if (idx_q == cnt_m1) begin
                if (found_q || match) begin
                  cnt_d = cnt_m1;
                  st_d  = ST_DELETED;
                end else begin
                  st_d  = ST_NOT_FOUND;
                end
                state_d = S_EMIT;
              end else begin
                idx_d   = idx_q + CntW'(1);
                state_d = S_READ;
              end
            end
          end
          // One entry per read, held until the output register frees
          CMD_LIST: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_st_d    = ST_ENTRY;
              out_val_d   = rd_data;
              out_cnt_d   = cnt_q;
              out_last_d  = (idx_q == list_n - CntW'(1));
              if (idx_q == list_n - CntW'(1)) begin
                state_d = S_IDLE;
              end else begin
                idx_d   = idx_q + CntW'(1);
                state_d = S_READ;
              end
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_PLACE: begin
        req.we      = 1'b1;
        req.wr_addr = idx_q[AddrW-1:0];
        req.wr_data = val_q;
        cnt_d       = cnt_q + CntW'(1);
        st_d        = ST_INSERTED;
        state_d     = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_val_d   = '0;
          out_cnt_d   = cnt_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    val_q      <= val_d;
    idx_q      <= idx_d;
    found_q    <= found_d;
    st_q       <= st_d;
    out_st_q   <= out_st_d;
    out_val_q  <= out_val_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign entry_value_o = $signed(out_val_q);
  assign entry_count_o = EntryCntW'(out_cnt_q);
  assign last_o        = out_last_q;

endmodule

// File: src/svt_store.sv
module svt_store (
  input  logic                      clk_i,
  input  svt_pkg::store_req_t       req_i,
  output logic [svt_pkg::ValueW-1:0] rd_data_o
);
  import svt_pkg::*;

  logic [ValueW-1:0] mem [Capacity];
  logic [ValueW-1:0] rd_data_q;

  // Single write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
